// ===== hdl/mmpd_pkg.sv =====
// mmpd_pkg: shared types and constants of the min/max plot decimator.
// Used by every module under hdl/ but mmpd_fifo; depends on nothing.
`default_nettype none

package mmpd_pkg;

  localparam int unsigned IDX_BITS = 16;
  localparam int unsigned CW_BITS  = 13;
  localparam int unsigned XS_BITS  = 24;
  localparam int unsigned POS_BITS = 25;

  localparam logic [IDX_BITS-1:0] RST_RECORD_LENGTH     = 16'd600;
  localparam logic [CW_BITS-1:0]  RST_CANVAS_WIDTH      = 13'd1024;
  localparam logic [XS_BITS-1:0]  RST_X_START           = 24'd0;
  localparam logic [IDX_BITS-1:0] RST_PASSTHROUGH_LIMIT = 16'd600;

  typedef enum logic [1:0] {
    REG_RECORD_LENGTH     = 2'd0,
    REG_CANVAS_WIDTH      = 2'd1,
    REG_X_START           = 2'd2,
    REG_PASSTHROUGH_LIMIT = 2'd3
  } reg_index_e;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_MIN    = 2'd1,
    KIND_MAX    = 2'd2
  } point_kind_e;

  typedef struct packed {
    logic [IDX_BITS-1:0] record_length;
    logic [CW_BITS-1:0]  canvas_width;
    logic [XS_BITS-1:0]  x_start;
    logic [IDX_BITS-1:0] passthrough_limit;
  } cfg_t;

  typedef struct packed {
    logic                busy;
    logic [IDX_BITS-1:0] seg_len;
    logic [IDX_BITS-1:0] span_end;
  } plan_t;

endpackage

`default_nettype wire

// ===== hdl/mmpd_plan.sv =====
// mmpd_plan: derives segment length and decimated span end from the registers.
// One shared restoring divider, two passes; depends on mmpd_pkg.
`default_nettype none

module mmpd_plan (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mmpd_pkg::cfg_t cfg_i,
  input  wire logic          cfg_wr_i,
  output mmpd_pkg::plan_t    plan_o
);
  import mmpd_pkg::*;

  localparam int unsigned DW = IDX_BITS + 1;
  localparam int unsigned CNT_BITS = $clog2(DW);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CEIL,
    ST_SPAN,
    ST_IDLE
  } state_e;

  state_e               state_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [DW-1:0]        quo_q;
  logic [DW-1:0]        rem_q;
  logic [DW-1:0]        div_q;
  logic [IDX_BITS-1:0]  seg_q;
  logic [IDX_BITS-1:0]  span_q;

  logic [IDX_BITS-1:0]  n_eff;
  logic [CW_BITS-1:0]   cw_eff;
  logic [DW:0]          trial;
  logic                 ge;
  logic [DW-1:0]        rem_d;
  logic [DW-1:0]        quo_d;

  always_comb begin
    n_eff  = (cfg_i.record_length == '0) ? IDX_BITS'(1) : cfg_i.record_length;
    cw_eff = (cfg_i.canvas_width == '0) ? CW_BITS'(1) : cfg_i.canvas_width;
    trial  = {rem_q, quo_q[DW-1]};
    ge     = trial >= {1'b0, div_q};
    rem_d  = ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
    quo_d  = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else if (cfg_wr_i) begin
      state_q <= ST_LOAD;
    end else begin
      case (state_q)
        ST_LOAD: begin
          quo_q   <= DW'(n_eff) + DW'(cw_eff) - DW'(1);
          rem_q   <= '0;
          div_q   <= DW'(cw_eff);
          cnt_q   <= '0;
          state_q <= ST_CEIL;
        end
        ST_CEIL: begin
          if (cnt_q == CNT_BITS'(DW - 1)) begin
            seg_q   <= quo_d[IDX_BITS-1:0];
            quo_q   <= DW'(n_eff);
            rem_q   <= '0;
            div_q   <= DW'(quo_d[IDX_BITS-1:0]);
            cnt_q   <= '0;
            state_q <= ST_SPAN;
          end else begin
            quo_q <= quo_d;
            rem_q <= rem_d;
            cnt_q <= cnt_q + CNT_BITS'(1);
          end
        end
        ST_SPAN: begin
          if (cnt_q == CNT_BITS'(DW - 1)) begin
            span_q  <= n_eff - rem_d[IDX_BITS-1:0];
            state_q <= ST_IDLE;
          end else begin
            quo_q <= quo_d;
            rem_q <= rem_d;
            cnt_q <= cnt_q + CNT_BITS'(1);
          end
        end
        ST_IDLE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign plan_o.busy     = (state_q != ST_IDLE);
  assign plan_o.seg_len  = seg_q;
  assign plan_o.span_end = span_q;

endmodule

`default_nettype wire

// ===== hdl/mmpd_front.sv =====
// mmpd_front: accepts samples, tracks record and segment position and min/max.
// Pushes one queue entry per single point or finished segment; uses mmpd_pkg.
`default_nettype none

module mmpd_front #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mmpd_pkg::cfg_t                cfg_i,
  input  wire mmpd_pkg::plan_t               plan_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output logic                               ent_seg_o,
  output logic                               ent_eor_o,
  output logic [mmpd_pkg::POS_BITS-1:0]      ent_pos_o,
  output logic signed [SAMPLE_BITS-1:0]      ent_lo_o,
  output logic signed [SAMPLE_BITS-1:0]      ent_hi_o
);
  import mmpd_pkg::*;

  logic [IDX_BITS-1:0]          idx_q, idx_d;
  logic [IDX_BITS-1:0]          off_q, off_d;
  logic [IDX_BITS-1:0]          seg_q;
  logic [IDX_BITS-1:0]          span_q;
  logic                         mode_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, lo_d;
  logic signed [SAMPLE_BITS-1:0] hi_q, hi_d;

  logic [IDX_BITS-1:0] n_eff;
  logic                first;
  logic [IDX_BITS-1:0] seg_use;
  logic [IDX_BITS-1:0] span_use;
  logic                mode_use;
  logic [IDX_BITS-1:0] off_use;
  logic                eor;
  logic                dec;
  logic                seg_end;
  logic                accept;

  always_comb begin
    n_eff    = (cfg_i.record_length == '0) ? IDX_BITS'(1) : cfg_i.record_length;
    first    = (idx_q == '0);
    seg_use  = first ? plan_i.seg_len : seg_q;
    span_use = first ? plan_i.span_end : span_q;
    mode_use = first ? (n_eff > cfg_i.passthrough_limit) : mode_q;
    off_use  = first ? '0 : off_q;
    eor      = ({1'b0, idx_q} + (IDX_BITS+1)'(1) >= {1'b0, n_eff}) || (&idx_q);
    dec      = mode_use && (idx_q < span_use);
    seg_end  = ({1'b0, off_use} + (IDX_BITS+1)'(1)) >= {1'b0, seg_use};

    in_stall_o = plan_i.busy || full_i;
    accept     = in_valid_i && !in_stall_o;

    if (off_use == '0) begin
      lo_d = sample_i;
      hi_d = sample_i;
    end else begin
      lo_d = (sample_i < lo_q) ? sample_i : lo_q;
      hi_d = (sample_i > hi_q) ? sample_i : hi_q;
    end

    off_d = off_use;
    if (dec) begin
      off_d = seg_end ? '0 : off_use + IDX_BITS'(1);
    end
    idx_d = idx_q + IDX_BITS'(1);
    if (eor) begin
      idx_d = '0;
      off_d = '0;
    end

    push_o    = accept && (!dec || seg_end);
    ent_seg_o = dec;
    ent_eor_o = eor;
    ent_pos_o = dec ? POS_BITS'(cfg_i.x_start) + POS_BITS'(idx_q - off_use)
                    : POS_BITS'(cfg_i.x_start) + POS_BITS'(idx_q);
    ent_lo_o  = dec ? lo_d : sample_i;
    ent_hi_o  = hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      off_q  <= '0;
      seg_q  <= '0;
      span_q <= '0;
      mode_q <= 1'b0;
    end else if (accept) begin
      idx_q <= idx_d;
      off_q <= off_d;
      if (first) begin
        seg_q  <= plan_i.seg_len;
        span_q <= plan_i.span_end;
        mode_q <= mode_use;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && dec) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mmpd_fifo.sv =====
// mmpd_fifo: short word queue between the front and back parts.
// Flop storage, one push (refused while full) and one pop (ignored while empty) per cycle; no package use.
`default_nettype none

module mmpd_fifo #(
  parameter int unsigned WIDTH = 75,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q;
  logic [PW-1:0]    rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mmpd_back.sv =====
// mmpd_back: drains queue entries into output words through an output register.
// A segment entry becomes a minimum word then a maximum word; uses mmpd_pkg.
`default_nettype none

module mmpd_back #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  input  wire logic                          ent_seg_i,
  input  wire logic                          ent_eor_i,
  input  wire logic [mmpd_pkg::POS_BITS-1:0] ent_pos_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ent_lo_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ent_hi_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mmpd_pkg::POS_BITS-1:0]      position_o,
  output logic signed [SAMPLE_BITS-1:0]      value_o,
  output logic [1:0]                         point_kind_o,
  output logic                               last_of_item_o,
  output logic                               end_of_record_o
);
  import mmpd_pkg::*;

  logic                          valid_q;
  logic                          pend_q;
  logic [POS_BITS-1:0]           hold_pos_q;
  logic signed [SAMPLE_BITS-1:0] hold_hi_q;
  logic                          hold_eor_q;
  logic [POS_BITS-1:0]           pos_q;
  logic signed [SAMPLE_BITS-1:0] val_q;
  point_kind_e                   kind_q;
  logic                          last_q;
  logic                          eor_q;
  logic                          advance;

  assign advance = !valid_q || !out_stall_i;
  assign pop_o   = advance && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (advance) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        pend_q  <= !empty_i && ent_seg_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (pend_q) begin
        pos_q  <= hold_pos_q;
        val_q  <= hold_hi_q;
        kind_q <= KIND_MAX;
        last_q <= 1'b1;
        eor_q  <= hold_eor_q;
      end else if (!empty_i) begin
        pos_q <= ent_pos_i;
        val_q <= ent_lo_i;
        if (ent_seg_i) begin
          kind_q     <= KIND_MIN;
          last_q     <= 1'b0;
          eor_q      <= 1'b0;
          hold_pos_q <= ent_pos_i;
          hold_hi_q  <= ent_hi_i;
          hold_eor_q <= ent_eor_i;
        end else begin
          kind_q <= KIND_SINGLE;
          last_q <= 1'b1;
          eor_q  <= ent_eor_i;
        end
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign position_o      = pos_q;
  assign value_o         = val_q;
  assign point_kind_o    = kind_q;
  assign last_of_item_o  = last_q;
  assign end_of_record_o = eor_q;

endmodule

`default_nettype wire

// ===== hdl/min_max_plot_decimator_core.sv =====
// min_max_plot_decimator_core: top level with the register port, plan unit,
// front part, word queue and back part; depends on mmpd_pkg and all mmpd_* modules.
`default_nettype none

// Thins a record of signed samples for plotting. A record longer than the
// passthrough limit is cut into segments of ceil(record_length/canvas_width)
// samples, each giving a minimum word then a maximum word at the segment start;
// other samples go out as single words. One sample is accepted per clock while
// in_stall_o is low; a segment end gives two words, so one-sample segments make
// in_stall_o rise once the queue (FIFO_DEPTH entries) fills. After reset and after
// any register write the plan unit runs its divider, and in_stall_o is high until
// the divider is done. Positions are x_start plus the sample index.
module min_max_plot_decimator_core #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mmpd_pkg::POS_BITS-1:0]      position_o,
  output logic signed [SAMPLE_BITS-1:0]      value_o,
  output logic [1:0]                         point_kind_o,
  output logic                               last_of_item_o,
  output logic                               end_of_record_o
);
  import mmpd_pkg::*;

  localparam int unsigned ENT_BITS = 2 + POS_BITS + 2 * SAMPLE_BITS;

  cfg_t        cfg_q;
  plan_t       plan;
  logic        cfg_wr;
  reg_index_e  reg_sel;

  logic                          push;
  logic                          pop;
  logic                          full;
  logic                          empty;
  logic                          f_seg, f_eor;
  logic [POS_BITS-1:0]           f_pos;
  logic signed [SAMPLE_BITS-1:0] f_lo, f_hi;
  logic                          b_seg, b_eor;
  logic [POS_BITS-1:0]           b_pos;
  logic signed [SAMPLE_BITS-1:0] b_lo, b_hi;
  logic [ENT_BITS-1:0]           wdata;
  logic [ENT_BITS-1:0]           rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_length     <= RST_RECORD_LENGTH;
      cfg_q.canvas_width      <= RST_CANVAS_WIDTH;
      cfg_q.x_start           <= RST_X_START;
      cfg_q.passthrough_limit <= RST_PASSTHROUGH_LIMIT;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_RECORD_LENGTH:     cfg_q.record_length     <= pwdata[IDX_BITS-1:0];
        REG_CANVAS_WIDTH:      cfg_q.canvas_width      <= pwdata[CW_BITS-1:0];
        REG_X_START:           cfg_q.x_start           <= pwdata[XS_BITS-1:0];
        REG_PASSTHROUGH_LIMIT: cfg_q.passthrough_limit <= pwdata[IDX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RECORD_LENGTH:     prdata = 32'(cfg_q.record_length);
      REG_CANVAS_WIDTH:      prdata = 32'(cfg_q.canvas_width);
      REG_X_START:           prdata = 32'(cfg_q.x_start);
      REG_PASSTHROUGH_LIMIT: prdata = 32'(cfg_q.passthrough_limit);
      default:               prdata = '0;
    endcase
  end

  mmpd_plan u_plan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_wr_i (cfg_wr),
    .plan_o   (plan)
  );

  mmpd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .plan_i     (plan),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .full_i     (full),
    .push_o     (push),
    .ent_seg_o  (f_seg),
    .ent_eor_o  (f_eor),
    .ent_pos_o  (f_pos),
    .ent_lo_o   (f_lo),
    .ent_hi_o   (f_hi)
  );

  assign wdata = {f_seg, f_eor, f_pos, f_lo, f_hi};

  mmpd_fifo #(
    .WIDTH (ENT_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_seg, b_eor, b_pos, b_lo, b_hi} = rdata;

  mmpd_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .pop_o           (pop),
    .ent_seg_i       (b_seg),
    .ent_eor_i       (b_eor),
    .ent_pos_i       (b_pos),
    .ent_lo_i        (b_lo),
    .ent_hi_i        (b_hi),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .position_o      (position_o),
    .value_o         (value_o),
    .point_kind_o    (point_kind_o),
    .last_of_item_o  (last_of_item_o),
    .end_of_record_o (end_of_record_o)
  );

endmodule

`default_nettype wire

// ===== sim/min_max_plot_decimator_checker.sv =====
`timescale 1ns / 1ps
// min_max_plot_decimator_checker: watches the sample, point and register ports of the
// decimator, predicts every point word and compares it field by field; uses mmpd_pkg.
module min_max_plot_decimator_checker #(
  parameter int unsigned SW = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [3:0]                    paddr_i,
  input  wire logic [31:0]                   pwdata_i,
  input  wire logic [31:0]                   prdata_i,
  input  wire logic                          pready_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic signed [SW-1:0]          sample_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [mmpd_pkg::POS_BITS-1:0] position_i,
  input  wire logic signed [SW-1:0]          value_i,
  input  wire logic [1:0]                    point_kind_i,
  input  wire logic                          last_of_item_i,
  input  wire logic                          end_of_record_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 samples_o,
  output int                                 points_o,
  output int                                 records_o
);
  import mmpd_pkg::*;

  typedef struct {
    logic [POS_BITS-1:0] position;
    logic signed [SW-1:0] value;
    point_kind_e          kind;
    logic                 last;
    logic                 eor;
  } plot_point_t;

  plot_point_t          due_points[$];
  cfg_t                 cfg;
  logic [IDX_BITS-1:0]  idx, offs, seg_len, span_end;
  logic signed [SW-1:0] lo, hi;
  logic                 decim;
  logic [31:0]          want;

  task automatic report(input string what, input longint got, input longint exp_val);
    fail_count_o++;
    if (fail_count_o <= 40)
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, exp_val);
  endtask

  // Plan is latched at the first sample of a record; end test uses the live length.
  task automatic take_sample(input logic signed [SW-1:0] s);
    int unsigned         n;
    int unsigned         c;
    logic [POS_BITS-1:0] at;
    logic                eor;
    samples_o++;
    n = (cfg.record_length == 0) ? 1 : cfg.record_length;
    if (idx == 0) begin
      c = (cfg.canvas_width == 0) ? 1 : cfg.canvas_width;
      seg_len = IDX_BITS'((n + c - 1) / c);
      span_end = IDX_BITS'((n / seg_len) * seg_len);
      decim = n > cfg.passthrough_limit;
      offs = '0;
    end
    eor = (idx + 32'd1 >= n) || (idx == '1);
    if (decim && idx < span_end) begin
      if (offs == 0) begin
        lo = s;
        hi = s;
      end else if (s < lo) begin
        lo = s;
      end else if (s > hi) begin
        hi = s;
      end
      if (offs + 32'd1 >= seg_len) begin
        at = POS_BITS'(cfg.x_start) + POS_BITS'(idx) - POS_BITS'(offs);
        due_points.push_back('{at, lo, KIND_MIN, 1'b0, 1'b0});
        due_points.push_back('{at, hi, KIND_MAX, 1'b1, eor});
        offs = '0;
      end else begin
        offs = offs + IDX_BITS'(1);
      end
    end else begin
      at = POS_BITS'(cfg.x_start) + POS_BITS'(idx);
      due_points.push_back('{at, s, KIND_SINGLE, 1'b1, eor});
    end
    if (eor) begin
      idx = '0;
      offs = '0;
    end else begin
      idx = idx + IDX_BITS'(1);
    end
  endtask

  task automatic check_point();
    plot_point_t p;
    points_o++;
    if (end_of_record_i) records_o++;
    if (due_points.size() == 0) begin
      report("unexpected word at position", position_i, -1);
    end else begin
      p = due_points.pop_front();
      if (position_i !== p.position) report("position", position_i, p.position);
      if (value_i !== p.value) report("value", value_i, p.value);
      if (point_kind_i !== p.kind) report("point_kind", point_kind_i, p.kind);
      if (last_of_item_i !== p.last) report("last_of_item", last_of_item_i, p.last);
      if (end_of_record_i !== p.eor) report("end_of_record", end_of_record_i, p.eor);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{RST_RECORD_LENGTH, RST_CANVAS_WIDTH, RST_X_START, RST_PASSTHROUGH_LIMIT};
      idx = '0;
      offs = '0;
      seg_len = '0;
      span_end = '0;
      lo = '0;
      hi = '0;
      decim = 1'b0;
      due_points.delete();
      fail_count_o = 0;
      samples_o = 0;
      points_o = 0;
      records_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_point();
      if (in_valid_i && !in_stall_i) take_sample(sample_i);
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (reg_index_e'(paddr_i[3:2]))
            REG_RECORD_LENGTH:     cfg.record_length = pwdata_i[IDX_BITS-1:0];
            REG_CANVAS_WIDTH:      cfg.canvas_width = pwdata_i[CW_BITS-1:0];
            REG_X_START:           cfg.x_start = pwdata_i[XS_BITS-1:0];
            REG_PASSTHROUGH_LIMIT: cfg.passthrough_limit = pwdata_i[IDX_BITS-1:0];
            default: begin
            end
          endcase
        end else begin
          case (reg_index_e'(paddr_i[3:2]))
            REG_RECORD_LENGTH:     want = 32'(cfg.record_length);
            REG_CANVAS_WIDTH:      want = 32'(cfg.canvas_width);
            REG_X_START:           want = 32'(cfg.x_start);
            REG_PASSTHROUGH_LIMIT: want = 32'(cfg.passthrough_limit);
            default:               want = '0;
          endcase
          if (prdata_i !== want) report("register readback", prdata_i, want);
        end
      end
    end
    pending_o = due_points.size();
  end

endmodule

// ===== sim/min_max_plot_decimator_core_test.sv =====
`timescale 1ns / 1ps
// min_max_plot_decimator_core_test: drives samples, register writes and output stalls
// into min_max_plot_decimator_core; relies on mmpd_pkg and min_max_plot_decimator_checker.
module min_max_plot_decimator_core_test;
  import mmpd_pkg::*;

  localparam int SW          = 24;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_GOAL   = 1250;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [3:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [SW-1:0]    sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b1;
  logic [POS_BITS-1:0]     position_o;
  logic signed [SW-1:0]    value_o;
  logic [1:0]              point_kind_o;
  logic                    last_of_item_o;
  logic                    end_of_record_o;

  int fail_count, pending, n_samples, n_points, n_records;
  int sent = 0;
  int settings = 0;
  int rx_hold = 0;
  int tx_style = 0;
  int tx_left = 0;
  int quiet = 0;

  min_max_plot_decimator_core #(.SAMPLE_BITS(SW)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .sample_i, .out_valid_o, .out_stall_i, .position_o,
    .value_o, .point_kind_o, .last_of_item_o, .end_of_record_o
  );

  min_max_plot_decimator_checker #(.SW(SW)) decimator_check (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .in_valid_i, .in_stall_i(in_stall_o), .sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .position_i(position_o),
    .value_i(value_o), .point_kind_i(point_kind_o), .last_of_item_i(last_of_item_o),
    .end_of_record_i(end_of_record_o),
    .fail_count_o(fail_count), .pending_o(pending), .samples_o(n_samples),
    .points_o(n_points), .records_o(n_records)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int pace(input int style);
    case (style)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return 24'sd0;
      3:       return -24'sd1;
      4, 5:    return SW'($signed($urandom_range(0, 15)) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  // Receiver: per-word stall gaps, plus a long hold-off when asked.
  initial begin : sink
    int gap;
    int style;
    int left;
    style = 0;
    left = 0;
    forever begin
      if (left == 0) begin
        style = $urandom_range(0, 2);
        left = $urandom_range(10, 60);
      end
      left--;
      if (rx_hold > 0) begin
        repeat (rx_hold) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        rx_hold = 0;
      end
      gap = pace(style);
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] s);
    int gap;
    if (tx_left == 0) begin
      tx_style = $urandom_range(0, 2);
      tx_left = $urandom_range(10, 60);
    end
    tx_left--;
    gap = pace(tx_style);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic send_many(input int cnt);
    repeat (cnt) send_sample(pick_sample());
  endtask

  // Wait until every predicted point is out, then let mid-segment samples drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input reg_index_e r, input logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input reg_index_e r, input logic [31:0] v);
    apb_access(1'b1, r, v);
    apb_access(1'b0, r, '0);
  endtask

  task automatic configure(input logic [15:0] rl, input logic [12:0] cw,
                           input logic [23:0] xs, input logic [15:0] pl);
    settle();
    set_reg(REG_RECORD_LENGTH, 32'(rl));
    set_reg(REG_CANVAS_WIDTH, 32'(cw));
    set_reg(REG_X_START, 32'(xs));
    set_reg(REG_PASSTHROUGH_LIMIT, 32'(pl));
    settings++;
  endtask

  initial begin : stimulus
    int          kind;
    int          k;
    logic [15:0] rl;
    logic [15:0] pl;
    logic [12:0] cw;
    logic [23:0] xs;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings pass samples through; shrink the length mid-record to end it
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    settle();
    set_reg(REG_RECORD_LENGTH, 32'd2);
    send_sample(24'sd0);

    // zero length and zero width act as one; top x_start
    configure(16'd0, 13'd0, 24'hFFFFFF, 16'd0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);

    // two segments of three, one trailing sample
    configure(16'd7, 13'd3, 24'd100, 16'd4);
    send_sample(24'sd5);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sd1);
    send_sample(24'sd0);
    send_sample(-24'sd1);
    send_sample(24'sd42);

    // record cut short inside a segment: no end-of-record word
    configure(16'd10, 13'd2, 24'd0, 16'd0);
    send_many(3);
    settle();
    set_reg(REG_RECORD_LENGTH, 32'd2);
    send_many(1);

    // length equal to the limit stays undecimated
    configure(16'd4, 13'd4096, 24'd1, 16'd4);
    send_many(4);

    // one-sample segments against a long receiver hold-off
    configure(16'd64, 13'd64, 24'd0, 16'd0);
    tx_style = 0;
    tx_left = 160;
    rx_hold = HOLD_OFF;
    send_many(128);

    while (sent < ITEM_GOAL) begin
      kind = $urandom_range(0, 9);
      xs = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
      if (kind <= 5) begin
        rl = 16'($urandom_range(1, 48));
        cw = 13'($urandom_range(1, 16));
        pl = 16'($urandom_range(0, rl - 1));
        configure(rl, cw, xs, pl);
        send_many($urandom_range(1, 3) * rl);
      end else if (kind == 6) begin
        rl = 16'($urandom_range(0, 40));
        pl = 16'($urandom_range(rl, 65535));
        cw = 13'($urandom_range(0, 4096));
        configure(rl, cw, xs, pl);
        send_many((rl == 0) ? 3 : 2 * rl);
      end else if (kind == 7) begin
        case ($urandom_range(0, 3))
          0:       cw = 13'd4096;
          1:       cw = 13'd4095;
          2:       cw = 13'd1;
          default: cw = 13'd0;
        endcase
        case ($urandom_range(0, 2))
          0:       pl = 16'd0;
          1:       pl = 16'd65534;
          default: pl = 16'd65535;
        endcase
        configure(16'hFFFF, cw, xs, pl);
        k = $urandom_range(20, 60);
        send_many(k);
        settle();
        set_reg(REG_RECORD_LENGTH, 32'($urandom_range(0, k)));
        send_many($urandom_range(1, 5));
      end else if (kind == 8) begin
        rl = 16'($urandom_range(4, 48));
        cw = 13'($urandom_range(1, 12));
        pl = 16'($urandom_range(0, rl));
        configure(rl, cw, xs, pl);
        send_many($urandom_range(1, rl - 1));
        settle();
        set_reg(REG_RECORD_LENGTH, 32'($urandom_range(0, 64)));
        send_many($urandom_range(1, 48));
      end else begin
        rl = 16'($urandom_range(100, 400));
        cw = 13'($urandom_range(1, 4096));
        pl = 16'($urandom_range(0, rl - 1));
        configure(rl, cw, xs, pl);
        send_many(rl);
      end
    end

    settle();
    $display("run: %0d samples, %0d point words, %0d closed records, %0d register settings",
             n_samples, n_points, n_records, settings);
    $display("run: extremes, zero length and width, cut-short records, long output hold-off");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
